>>> sv/ookpwt_pkg.sv
// Shared constants, types and widths for the OOK pulse-width pager transmitter.
package ookpwt_pkg;

   // Code word and timer sizing
   localparam int MAX_CODE_BITS  = 31;
   localparam int TIMER_WIDTH    = 16;
   localparam int CODE_WIDTH     = 31;
   localparam int COUNT_WIDTH    = 5;
   localparam int CHIP_CNT_WIDTH = $clog2(MAX_CODE_BITS * 4 + 1);
   localparam int LIMIT_WIDTH    = 16;
   localparam int CMP_WIDTH      = (TIMER_WIDTH > LIMIT_WIDTH) ? TIMER_WIDTH : LIMIT_WIDTH;

   // Register port sizing
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXTRA_REPEATS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_DELAY   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETUP_TICKS   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS    = 2'd3;

   // Register reset values
   localparam logic [15:0] EXTRA_REPEATS_RST = 16'd32;
   localparam logic [15:0] START_DELAY_RST   = 16'd0;
   localparam logic [7:0]  SETUP_TICKS_RST   = 8'd0;
   localparam logic [7:0]  HOLD_TICKS_RST    = 8'd25;

   // Chip patterns, sent from bit 3 downwards
   localparam logic [3:0] SYM_ZERO = 4'h8;
   localparam logic [3:0] SYM_ONE  = 4'hE;

   // Radio mode codes
   localparam logic [1:0] MODE_STANDBY = 2'd0;
   localparam logic [1:0] MODE_FS      = 2'd1;
   localparam logic [1:0] MODE_CW      = 2'd2;

   // Input item function codes
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DELAY = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_SEND  = 5'b01000,
      ST_HOLD  = 5'b10000
   } ctrl_state_type;

endpackage

>>> sv/ookpwt_ifs.sv
// Handshake channel interfaces for request, result and register write items.
interface ookpwt_req_if;
   import ookpwt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [CODE_WIDTH-1:0]  code_word;
   logic [COUNT_WIDTH-1:0] code_bits;
   modport source (output valid, func, code_word, code_bits, input ready);
   modport sink   (input valid, func, code_word, code_bits, output ready);
endinterface

interface ookpwt_rsp_if;
   logic       valid;
   logic       ready;
   logic       request_accepted;
   logic       busy_res;
   logic [1:0] radio_mode;
   logic       command_issued;
   modport source (output valid, request_accepted, busy_res, radio_mode, command_issued,
                   input ready);
   modport sink   (input valid, request_accepted, busy_res, radio_mode, command_issued,
                   output ready);
endinterface

interface ookpwt_csr_if;
   import ookpwt_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] reg_index;
   logic [CSR_DATA_WIDTH-1:0]  wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> sv/ook_pulse_width_pager_transmitter_unit.sv
// Top level of the OOK pulse-width pager transmitter sequencer.
// Each accepted item yields its result item in the output register on the next cycle.
// Throughput: one item per cycle while the result channel is ready; the next item is taken
// while the result is taken, as the state update feeds the result register directly.
// Reset (synchronous, active high): sequencer idle, no request pending, radio standby,
// registers at their reset values, no result item held.
module ook_pulse_width_pager_transmitter_unit (
   input logic         clock,
   input logic         reset,
   ookpwt_req_if.sink   req_chan,
   ookpwt_rsp_if.source rsp_chan,
   ookpwt_csr_if.sink   csr_chan
);
   import ookpwt_pkg::*;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   // Configuration registers
   logic [15:0] extra_repeats_ff;
   logic [15:0] start_delay_ff;
   logic [7:0]  setup_ticks_ff;
   logic [7:0]  hold_ticks_ff;

   // Sequencer state
   ctrl_state_type              state_ff, state_in;
   logic                        pending_ff, pending_in;
   logic [CODE_WIDTH-1:0]       code_ff, code_in;
   logic [COUNT_WIDTH-1:0]      count_ff, count_in;
   logic [CHIP_CNT_WIDTH-1:0]   chips_left_ff, chips_left_in;
   logic [15:0]                 repeats_left_ff, repeats_left_in;
   logic [TIMER_WIDTH-1:0]      timer_ff, timer_in;
   logic                        last_known_ff, last_known_in;
   logic                        last_level_ff, last_level_in;
   logic [1:0]                  mode_ff, mode_in;

   // Result register
   logic       rsp_valid_ff;
   logic       rsp_accepted_ff, rsp_busy_ff, rsp_cmd_ff;
   logic [1:0] rsp_mode_ff;

   // Handshake
   logic req_fire;
   logic csr_fire;

   // Datapath helpers
   logic [TIMER_WIDTH-1:0]    timer_inc;
   logic [CMP_WIDTH-1:0]      wait_limit;
   logic                      wait_done;
   logic [CHIP_CNT_WIDTH-1:0] chips_dec;
   logic                      code_bit;
   logic [3:0]                sym;
   logic                      chip;
   logic                      accepted;
   logic                      cmd;

   // Take an item whenever the result register is free or being emptied
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         extra_repeats_ff <= EXTRA_REPEATS_RST;
         start_delay_ff   <= START_DELAY_RST;
         setup_ticks_ff   <= SETUP_TICKS_RST;
         hold_ticks_ff    <= HOLD_TICKS_RST;
      end else if (csr_fire) begin
         case (csr_chan.reg_index)
            CSR_EXTRA_REPEATS: extra_repeats_ff <= csr_chan.wdata;
            CSR_START_DELAY:   start_delay_ff   <= csr_chan.wdata;
            CSR_SETUP_TICKS:   setup_ticks_ff   <= csr_chan.wdata[7:0];
            CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_chan.wdata[7:0];
            default: ;
         endcase
      end
   end

   // Saturating timer advance and end-of-wait compare
   assign timer_inc = (timer_ff != TIMER_MAX) ? TIMER_WIDTH'(timer_ff + 1'b1) : timer_ff;

   always_comb begin
      case (state_ff)
         ST_DELAY: wait_limit = CMP_WIDTH'(start_delay_ff);
         ST_SETUP: wait_limit = CMP_WIDTH'(setup_ticks_ff);
         ST_HOLD:  wait_limit = CMP_WIDTH'(hold_ticks_ff);
         default:  wait_limit = '0;
      endcase
   end

   assign wait_done = (CMP_WIDTH'(timer_inc) >= wait_limit) || (timer_inc == TIMER_MAX);

   // Select the chip after the count steps down
   assign chips_dec = CHIP_CNT_WIDTH'(chips_left_ff - 1'b1);
   assign code_bit  = code_ff[chips_dec[CHIP_CNT_WIDTH-1:2]];
   assign sym       = code_bit ? SYM_ONE : SYM_ZERO;
   assign chip      = sym[chips_dec[1:0]];

   // Step the sequencer for one item
   always_comb begin
      state_in        = state_ff;
      pending_in      = pending_ff;
      code_in         = code_ff;
      count_in        = count_ff;
      chips_left_in   = chips_left_ff;
      repeats_left_in = repeats_left_ff;
      timer_in        = timer_ff;
      last_known_in   = last_known_ff;
      last_level_in   = last_level_ff;
      mode_in         = mode_ff;
      accepted        = 1'b0;
      cmd             = 1'b0;

      if (req_chan.func == FUNC_REQUEST) begin
         // Load a new code word unless a frame sequence is under way
         if (!pending_ff) begin
            code_in    = req_chan.code_word;
            count_in   = (req_chan.code_bits > COUNT_WIDTH'(MAX_CODE_BITS)) ?
                         COUNT_WIDTH'(MAX_CODE_BITS) : req_chan.code_bits;
            pending_in = 1'b1;
            accepted   = 1'b1;
         end
      end else begin
         case (state_ff)
            ST_DELAY: begin
               timer_in = timer_inc;
               if (wait_done) begin
                  mode_in  = MODE_FS;
                  cmd      = 1'b1;
                  timer_in = '0;
                  state_in = ST_SETUP;
               end
            end
            ST_SETUP: begin
               timer_in = timer_inc;
               if (wait_done) begin
                  last_known_in = 1'b0;
                  chips_left_in = CHIP_CNT_WIDTH'({count_ff, 2'b00});
                  state_in      = ST_SEND;
               end
            end
            ST_SEND: begin
               if (chips_left_ff != '0) begin
                  chips_left_in = chips_dec;
                  if (!last_known_ff || (chip != last_level_ff)) begin
                     mode_in       = chip ? MODE_CW : MODE_FS;
                     cmd           = 1'b1;
                     last_known_in = 1'b1;
                     last_level_in = chip;
                  end
               end else begin
                  // Force the carrier off at the end of the frame
                  mode_in  = MODE_FS;
                  cmd      = 1'b1;
                  timer_in = '0;
                  state_in = ST_HOLD;
               end
            end
            ST_HOLD: begin
               timer_in = timer_inc;
               if (wait_done) begin
                  if (repeats_left_ff != '0) begin
                     repeats_left_in = repeats_left_ff - 16'd1;
                     timer_in        = '0;
                     state_in        = ST_SETUP;
                  end else begin
                     mode_in    = MODE_STANDBY;
                     cmd        = 1'b1;
                     pending_in = 1'b0;
                     state_in   = ST_IDLE;
                  end
               end
            end
            default: begin
               state_in = ST_IDLE;
               if (pending_ff) begin
                  repeats_left_in = extra_repeats_ff;
                  timer_in        = '0;
                  state_in        = ST_DELAY;
               end
            end
         endcase
      end
   end

   // Advance control state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pending_ff      <= 1'b0;
         chips_left_ff   <= '0;
         repeats_left_ff <= '0;
         timer_ff        <= '0;
         last_known_ff   <= 1'b0;
         mode_ff         <= MODE_STANDBY;
      end else if (req_fire) begin
         state_ff        <= state_in;
         pending_ff      <= pending_in;
         chips_left_ff   <= chips_left_in;
         repeats_left_ff <= repeats_left_in;
         timer_ff        <= timer_in;
         last_known_ff   <= last_known_in;
         mode_ff         <= mode_in;
      end
   end

   // Hold stored code word and chip level
   always_ff @(posedge clock) begin
      if (req_fire) begin
         code_ff       <= code_in;
         count_ff      <= count_in;
         last_level_ff <= last_level_in;
      end
   end

   // Hold the result item until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_accepted_ff <= accepted;
         rsp_busy_ff     <= pending_in;
         rsp_mode_ff     <= mode_in;
         rsp_cmd_ff      <= cmd;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.request_accepted = rsp_accepted_ff;
   assign rsp_chan.busy_res         = rsp_busy_ff;
   assign rsp_chan.radio_mode       = rsp_mode_ff;
   assign rsp_chan.command_issued   = rsp_cmd_ff;

   // No request pending means the sequencer rests in idle
   a_idle_when_free: assert property (@(posedge clock) disable iff (reset)
      !pending_ff |-> state_ff == ST_IDLE)
      else $error("sequencer active without a pending request");

   // Radio is never in standby during setup, chips or hold
   a_mode_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP || state_ff == ST_SEND || state_ff == ST_HOLD)
      |-> mode_ff != MODE_STANDBY)
      else $error("radio in standby while a frame is in progress");

   // Every accepted item yields a result item in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule
